// ===== design/dps_pkg.sv =====
package dps_pkg;

    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAULT_TIMEOUT    = 3'd0,
        CFG_SETTLE_TICKS     = 3'd1,
        CFG_ARRIVE_TOLERANCE = 3'd2,
        CFG_TEST_OFFSET      = 3'd3,
        CFG_REFERENCE_SCALE  = 3'd4
    } cfg_index_t;

    localparam logic [15:0] FAULT_TIMEOUT_RST    = 16'd5000;
    localparam logic [15:0] SETTLE_TICKS_RST     = 16'd4000;
    localparam logic [7:0]  ARRIVE_TOLERANCE_RST = 8'd2;
    localparam logic [19:0] TEST_OFFSET_RST      = 20'd5000;
    localparam logic [7:0]  REFERENCE_SCALE_RST  = 8'd57;

    localparam logic signed [15:0] REF_MAX = 16'sd2047;
    localparam logic signed [15:0] REF_MIN = -16'sd2048;

    localparam logic [4:0] STAT_FAULT      = 5'h01;
    localparam logic [4:0] STAT_READY      = 5'h02;
    localparam logic [4:0] STAT_POWER_ON   = 5'h08;
    localparam logic [4:0] STAT_IDLE_READY = 5'h10;

    localparam logic [7:0] CTRL_BRAKE_OFF = 8'h04;
    localparam logic [7:0] CTRL_POWER_ON  = 8'h10;
    localparam logic [7:0] CTRL_STAGE_ON  = 8'h40;

    typedef struct packed {
        logic [15:0] fault_timeout;
        logic [15:0] settle_ticks;
        logic [7:0]  arrive_tolerance;
        logic [19:0] test_offset;
        logic [7:0]  reference_scale;
    } cfg_t;

    typedef struct packed {
        logic               ok;
        logic signed [11:0] reference;
        logic [7:0]         control;
        logic signed [20:0] offset;
    } frame_t;

    typedef struct packed {
        logic [2:0]         mode_index;
        logic [4:0]         status_byte;
        logic               motor_enable;
        logic               brake_release;
        logic               regulate;
        logic signed [31:0] position_error;
        logic               frame_ok;
        logic signed [11:0] command_reference;
    } res_t;

endpackage

// ===== design/dps_req_if.sv =====
interface dps_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] measured_position;
    logic [63:0]        frame_bytes;

    modport source
    (
        output valid,
        output opcode,
        output measured_position,
        output frame_bytes,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  opcode,
        input  measured_position,
        input  frame_bytes,
        output ready
    );
endinterface

// ===== design/dps_res_if.sv =====
interface dps_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode_index;
    logic [4:0]         status_byte;
    logic               motor_enable;
    logic               brake_release;
    logic               regulate;
    logic signed [31:0] position_error;
    logic               frame_ok;
    logic signed [11:0] command_reference;

    modport source
    (
        output valid,
        output mode_index,
        output status_byte,
        output motor_enable,
        output brake_release,
        output regulate,
        output position_error,
        output frame_ok,
        output command_reference,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  mode_index,
        input  status_byte,
        input  motor_enable,
        input  brake_release,
        input  regulate,
        input  position_error,
        input  frame_ok,
        input  command_reference,
        output ready
    );
endinterface

// ===== design/dps_cfg_regs.sv =====
module dps_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dps_pkg::cfg_t                   cfg
);

    dps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_timeout    <= dps_pkg::FAULT_TIMEOUT_RST;
            cfg_reg.settle_ticks     <= dps_pkg::SETTLE_TICKS_RST;
            cfg_reg.arrive_tolerance <= dps_pkg::ARRIVE_TOLERANCE_RST;
            cfg_reg.test_offset      <= dps_pkg::TEST_OFFSET_RST;
            cfg_reg.reference_scale  <= dps_pkg::REFERENCE_SCALE_RST;
        end
        else if (cfg_we)
        begin
            // unknown indexes are dropped
            unique case (cfg_index)
                dps_pkg::CFG_FAULT_TIMEOUT:    cfg_reg.fault_timeout    <= cfg_data[15:0];
                dps_pkg::CFG_SETTLE_TICKS:     cfg_reg.settle_ticks     <= cfg_data[15:0];
                dps_pkg::CFG_ARRIVE_TOLERANCE: cfg_reg.arrive_tolerance <= cfg_data[7:0];
                dps_pkg::CFG_TEST_OFFSET:      cfg_reg.test_offset      <= cfg_data[19:0];
                dps_pkg::CFG_REFERENCE_SCALE:  cfg_reg.reference_scale  <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dps_frame_decode.sv =====
module dps_frame_decode
(
    input  logic [63:0]      frame_bytes,
    input  logic [7:0]       reference_scale,
    output dps_pkg::frame_t  frm
);

    logic [7:0]         checksum;
    logic signed [15:0] raw_ref;
    logic signed [11:0] clamped;
    logic signed [8:0]  scale_s;

    always_comb
    begin
        checksum = 8'd0;
        for (int k = 0; k < 8; k++)
        begin
            checksum = checksum ^ frame_bytes[8*k +: 8];
        end
    end

    assign raw_ref = signed'(frame_bytes[15:0]);

    always_comb
    begin
        if (raw_ref > dps_pkg::REF_MAX)
        begin
            clamped = dps_pkg::REF_MAX[11:0];
        end
        else if (raw_ref < dps_pkg::REF_MIN)
        begin
            clamped = dps_pkg::REF_MIN[11:0];
        end
        else
        begin
            clamped = raw_ref[11:0];
        end
    end

    assign scale_s       = signed'({1'b0, reference_scale});
    assign frm.ok        = (checksum == 8'd0);
    assign frm.reference = clamped;
    assign frm.control   = frame_bytes[55:48];
    assign frm.offset    = scale_s * clamped;

endmodule

// ===== design/dps_core.sv =====
module dps_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               opcode,
    input  logic signed [31:0] measured_position,
    input  dps_pkg::frame_t    frm,
    input  dps_pkg::cfg_t      cfg,
    output dps_pkg::res_t      res
);

    typedef enum logic [2:0] {
        MODE_WAIT   = 3'd0,
        MODE_TEST1  = 3'd1,
        MODE_TEST2  = 3'd2,
        MODE_TEST3  = 3'd3,
        MODE_LAUNCH = 3'd4,
        MODE_REMOTE = 3'd5,
        MODE_FAULT  = 3'd6
    } mode_t;

    mode_t              mode_reg,      mode_next;
    dps_pkg::pos_t      target_reg,    target_next;
    dps_pkg::pos_t      zero_reg,      zero_next;
    logic [15:0]        timer_reg,     timer_next;
    logic [4:0]         status_reg,    status_next;
    logic [7:0]         control_reg,   control_next;
    logic signed [11:0] last_ref_reg,  last_ref_next;
    logic               motor_reg,     motor_next;
    logic               brake_reg,     brake_next;

    dps_pkg::pos_t      meas_p;
    dps_pkg::pos_t      err;
    dps_pkg::pos_t      abs_err;
    dps_pkg::pos_t      offset_p;
    logic               arrived;
    logic [15:0]        timer_inc;
    logic               regulate;
    logic               frame_ok;
    logic signed [31:0] err_out;

    assign meas_p    = dps_pkg::POS_W'(measured_position);
    assign err       = target_reg - meas_p;
    assign abs_err   = err[dps_pkg::POS_W-1] ? (~err + 1'b1) : err;
    assign arrived   = (abs_err <= dps_pkg::POS_W'(cfg.arrive_tolerance));
    assign timer_inc = timer_reg + 16'd1;
    assign offset_p  = dps_pkg::POS_W'(cfg.test_offset);

    always_comb
    begin
        mode_next     = mode_reg;
        target_next   = target_reg;
        zero_next     = zero_reg;
        timer_next    = timer_reg;
        status_next   = status_reg;
        control_next  = control_reg;
        last_ref_next = last_ref_reg;
        motor_next    = motor_reg;
        brake_next    = brake_reg;
        regulate      = 1'b0;
        frame_ok      = 1'b0;
        err_out       = '0;

        if (opcode)
        begin
            if (frm.ok)
            begin
                last_ref_next = frm.reference;
                target_next   = dps_pkg::POS_W'(frm.offset) + zero_reg;
                control_next  = frm.control;
                frame_ok      = 1'b1;
            end
        end
        else
        begin
            err_out = 32'(signed'(err));
            unique case (mode_reg)
                MODE_WAIT:
                begin
                    status_next = dps_pkg::STAT_IDLE_READY;
                    if ((control_reg & dps_pkg::CTRL_POWER_ON) != 8'd0)
                    begin
                        zero_next   = meas_p;
                        target_next = meas_p + offset_p;
                        mode_next   = MODE_TEST1;
                        timer_next  = '0;
                        status_next = dps_pkg::STAT_IDLE_READY | dps_pkg::STAT_POWER_ON;
                        motor_next  = 1'b1;
                        brake_next  = 1'b1;
                    end
                end
                MODE_TEST1, MODE_TEST2, MODE_TEST3:
                begin
                    if (timer_reg >= cfg.fault_timeout)
                    begin
                        // drive outputs follow on the next tick in fault mode
                        mode_next = MODE_FAULT;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                        if (mode_reg == MODE_TEST1)
                        begin
                            if (arrived)
                            begin
                                target_next = zero_reg - offset_p;
                                mode_next   = MODE_TEST2;
                                timer_next  = '0;
                            end
                            else
                            begin
                                regulate = 1'b1;
                            end
                        end
                        else if (mode_reg == MODE_TEST2)
                        begin
                            if (arrived)
                            begin
                                target_next = zero_reg;
                                mode_next   = MODE_TEST3;
                                timer_next  = '0;
                            end
                            regulate = 1'b1;
                        end
                        else
                        begin
                            if (arrived && (timer_inc >= cfg.settle_ticks))
                            begin
                                target_next = zero_reg;
                                mode_next   = MODE_LAUNCH;
                                timer_next  = '0;
                                motor_next  = 1'b0;
                                brake_next  = 1'b0;
                            end
                            else
                            begin
                                regulate = 1'b1;
                            end
                        end
                    end
                end
                MODE_LAUNCH:
                begin
                    status_next = status_reg | dps_pkg::STAT_POWER_ON;
                    if ((control_reg & dps_pkg::CTRL_STAGE_ON) == 8'd0)
                    begin
                        mode_next = MODE_FAULT;
                    end
                    else
                    begin
                        motor_next = 1'b1;
                        if ((control_reg & dps_pkg::CTRL_BRAKE_OFF) != 8'd0)
                        begin
                            mode_next  = MODE_REMOTE;
                            brake_next = 1'b1;
                        end
                    end
                end
                MODE_REMOTE:
                begin
                    status_next = status_reg | dps_pkg::STAT_READY;
                    regulate    = 1'b1;
                end
                default:
                begin
                    // fault, and the unused code as well
                    mode_next   = MODE_FAULT;
                    status_next = dps_pkg::STAT_FAULT;
                    motor_next  = 1'b0;
                    brake_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_WAIT;
            target_reg   <= '0;
            zero_reg     <= '0;
            timer_reg    <= '0;
            status_reg   <= '0;
            control_reg  <= '0;
            last_ref_reg <= '0;
            motor_reg    <= 1'b0;
            brake_reg    <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            target_reg   <= target_next;
            zero_reg     <= zero_next;
            timer_reg    <= timer_next;
            status_reg   <= status_next;
            control_reg  <= control_next;
            last_ref_reg <= last_ref_next;
            motor_reg    <= motor_next;
            brake_reg    <= brake_next;
        end
    end

    assign res.mode_index        = mode_next;
    assign res.status_byte       = status_next;
    assign res.motor_enable      = motor_next;
    assign res.brake_release     = brake_next;
    assign res.regulate          = regulate;
    assign res.position_error    = err_out;
    assign res.frame_ok          = frame_ok;
    assign res.command_reference = last_ref_next;

endmodule

// ===== design/drive_positioning_supervisor.sv =====
// Servo drive positioning supervisor.
// Requests arrive on req: opcode 1 is a command frame (frame_bytes, eight
// bytes whose XOR must be zero), opcode 0 is a control tick carrying
// measured_position. Every request gives exactly one result on res: mode,
// status byte, motor and brake commands, the position error with its
// regulate flag, the frame check flag and the last accepted reference.
// Registers are to be written through cfg_we / cfg_index / cfg_data only
// while no request is in flight; the block does not enforce this. Indexes
// beyond the register list are ignored. The request register loads at
// acceptance, and the sequencer and frame decode evaluate from it in a
// single pass into the result register, which drives res.valid. One
// request per cycle is taken while res.ready stays high, set by that
// single registered pass.
// Reset puts the sequencer in wait mode with motor off and brake applied,
// clears target, zero phase and control word, and loads register defaults.
// When res.ready is low the result holds and the request register keeps
// one more request; req.ready drops only when both are full.
module drive_positioning_supervisor
(
    input  logic                            clk,
    input  logic                            rst_n,
    dps_req_if.sink                         req,
    dps_res_if.source                       res,
    input  logic                            cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic               req_v_reg;
    logic               opcode_reg;
    logic signed [31:0] meas_reg;
    logic [63:0]        frame_reg;
    logic               res_v_reg;
    dps_pkg::res_t      res_reg;

    dps_pkg::cfg_t      cfg;
    dps_pkg::frame_t    frm;
    dps_pkg::res_t      res_next;
    logic               advance;

    assign advance   = req_v_reg && (!res_v_reg || res.ready);
    assign req.ready = !req_v_reg || advance;

    dps_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dps_frame_decode u_frame
    (
        .frame_bytes     (frame_reg),
        .reference_scale (cfg.reference_scale),
        .frm             (frm)
    );

    dps_core u_core
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .opcode            (opcode_reg),
        .measured_position (meas_reg),
        .frm               (frm),
        .cfg               (cfg),
        .res               (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                req_v_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_v_reg <= 1'b0;
            end

            if (advance)
            begin
                res_v_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_v_reg <= 1'b0;
            end
        end
    end

    // payloads load on acceptance, res_reg on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            opcode_reg <= req.opcode;
            meas_reg   <= req.measured_position;
            frame_reg  <= req.frame_bytes;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid             = res_v_reg;
    assign res.mode_index        = res_reg.mode_index;
    assign res.status_byte       = res_reg.status_byte;
    assign res.motor_enable      = res_reg.motor_enable;
    assign res.brake_release     = res_reg.brake_release;
    assign res.regulate          = res_reg.regulate;
    assign res.position_error    = res_reg.position_error;
    assign res.frame_ok          = res_reg.frame_ok;
    assign res.command_reference = res_reg.command_reference;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int          CYCLE_LIMIT     = 300000;
    localparam int          HOLD_OFF_CYCLES = 120;
    localparam int          TOTAL_REQUESTS  = 1400;
    localparam logic        OP_TICK         = 1'b0;
    localparam logic        OP_FRAME        = 1'b1;
    localparam logic [2:0]  CFG_UNUSED_IDX  = 3'd5;

    typedef enum logic [2:0] {
        MODE_WAIT   = 3'd0,
        MODE_TEST1  = 3'd1,
        MODE_TEST2  = 3'd2,
        MODE_TEST3  = 3'd3,
        MODE_LAUNCH = 3'd4,
        MODE_REMOTE = 3'd5,
        MODE_FAULT  = 3'd6
    } mode_e;

    typedef enum int {
        END_REMOTE,
        END_LAUNCH_REFUSED,
        END_TEST_TIMEOUT
    } ending_e;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we;
    logic [dps_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [dps_pkg::CFG_DATA_W-1:0]  cfg_data;

    dps_req_if req_bus();
    dps_res_if res_bus();

    drive_positioning_supervisor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Supervisor state as predicted from accepted requests
    dps_pkg::cfg_t regs = '{dps_pkg::FAULT_TIMEOUT_RST, dps_pkg::SETTLE_TICKS_RST,
                            dps_pkg::ARRIVE_TOLERANCE_RST, dps_pkg::TEST_OFFSET_RST,
                            dps_pkg::REFERENCE_SCALE_RST};
    logic [2:0]   m_mode      = MODE_WAIT;
    logic [31:0]  m_target    = '0;
    logic [31:0]  m_zero      = '0;
    logic [15:0]  m_timer     = '0;
    logic [4:0]   m_status    = '0;
    logic [7:0]   m_control   = '0;
    logic [11:0]  m_reference = '0;
    logic         m_motor     = 1'b0;
    logic         m_brake_off = 1'b0;

    dps_pkg::res_t expected_results[$];
    int unsigned  failures = 0;
    int unsigned  items_sent = 0;
    int unsigned  burst_left = 0;
    int unsigned  cycles = 0;
    int unsigned  hold_off_requests = 0;
    int unsigned  hold_off_served = 0;
    ending_e      ending;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic dps_pkg::res_t supervise_request(logic op, logic [31:0] meas,
                                                        logic [63:0] fb);
        logic [7:0]         xsum;
        logic signed [15:0] raw;
        int                 r;
        longint             scaled;
        logic [31:0]        err;
        longint             serr;
        logic               arrived;
        dps_pkg::res_t      out;
        out = '0;
        if (op == OP_FRAME)
        begin
            xsum = '0;
            for (int k = 0; k < 8; k++)
                xsum ^= fb[8*k +: 8];
            if (xsum == 8'h00)
            begin
                raw = fb[15:0];
                r = raw;
                if (r > dps_pkg::REF_MAX)
                    r = dps_pkg::REF_MAX;
                if (r < dps_pkg::REF_MIN)
                    r = dps_pkg::REF_MIN;
                m_reference = r[11:0];
                scaled = longint'(regs.reference_scale) * longint'(r) + longint'(m_zero);
                m_target = scaled[31:0];
                m_control = fb[55:48];
                out.frame_ok = 1'b1;
            end
        end
        else
        begin
            err = m_target - meas;
            serr = longint'($signed(err));
            if (serr < 0)
                serr = -serr;
            arrived = serr <= longint'(regs.arrive_tolerance);
            out.position_error = err;
            case (m_mode)
                MODE_WAIT:
                begin
                    m_status = dps_pkg::STAT_IDLE_READY;
                    if ((m_control & dps_pkg::CTRL_POWER_ON) != 8'h00)
                    begin
                        m_zero = meas;
                        m_target = meas + 32'(regs.test_offset);
                        m_mode = MODE_TEST1;
                        m_timer = '0;
                        m_status |= dps_pkg::STAT_POWER_ON;
                        m_motor = 1'b1;
                        m_brake_off = 1'b1;
                    end
                end
                MODE_TEST1, MODE_TEST2, MODE_TEST3:
                begin
                    if (m_timer >= regs.fault_timeout)
                        m_mode = MODE_FAULT;
                    else
                    begin
                        m_timer = m_timer + 16'd1;
                        if (m_mode == MODE_TEST1)
                        begin
                            if (arrived)
                            begin
                                m_target = m_zero - 32'(regs.test_offset);
                                m_mode = MODE_TEST2;
                                m_timer = '0;
                            end
                            else
                                out.regulate = 1'b1;
                        end
                        else if (m_mode == MODE_TEST2)
                        begin
                            if (arrived)
                            begin
                                m_target = m_zero;
                                m_mode = MODE_TEST3;
                                m_timer = '0;
                            end
                            out.regulate = 1'b1;
                        end
                        else if (arrived && m_timer >= regs.settle_ticks)
                        begin
                            m_target = m_zero;
                            m_mode = MODE_LAUNCH;
                            m_timer = '0;
                            m_motor = 1'b0;
                            m_brake_off = 1'b0;
                        end
                        else
                            out.regulate = 1'b1;
                    end
                end
                MODE_LAUNCH:
                begin
                    m_status |= dps_pkg::STAT_POWER_ON;
                    if ((m_control & dps_pkg::CTRL_STAGE_ON) == 8'h00)
                        m_mode = MODE_FAULT;
                    else
                    begin
                        m_motor = 1'b1;
                        if ((m_control & dps_pkg::CTRL_BRAKE_OFF) != 8'h00)
                        begin
                            m_mode = MODE_REMOTE;
                            m_brake_off = 1'b1;
                        end
                    end
                end
                MODE_REMOTE:
                begin
                    m_status |= dps_pkg::STAT_READY;
                    out.regulate = 1'b1;
                end
                default:
                begin
                    m_mode = MODE_FAULT;
                    m_status = dps_pkg::STAT_FAULT;
                    m_motor = 1'b0;
                    m_brake_off = 1'b0;
                end
            endcase
        end
        out.mode_index = m_mode;
        out.status_byte = m_status;
        out.motor_enable = m_motor;
        out.brake_release = m_brake_off;
        out.command_reference = m_reference;
        return out;
    endfunction

    // Bytes 0..1 reference, 2..5 filler, 6 control, 7 chosen so all eight XOR to zero
    function automatic logic [63:0] make_frame(logic [15:0] reference, logic [7:0] control);
        logic [63:0] fb;
        logic [7:0]  xsum;
        fb = {8'h00, control, 32'($urandom), reference};
        xsum = '0;
        for (int k = 0; k < 7; k++)
            xsum ^= fb[8*k +: 8];
        fb[63:56] = xsum;
        return fb;
    endfunction

    function automatic logic [63:0] random_frame();
        logic [15:0] reference;
        logic [63:0] fb;
        if ($urandom_range(0, 3) == 0)
            reference = 16'($urandom);
        else
            reference = 16'(int'($urandom_range(0, 4095)) - 2048);
        fb = make_frame(reference, 8'($urandom));
        // corrupt a quarter of them
        if ($urandom_range(0, 3) == 0)
            fb ^= 64'd1 << $urandom_range(0, 63);
        return fb;
    endfunction

    // Pick a position near the current target, inside the tolerance or just outside it, or at times a random one
    function automatic logic [31:0] tick_position(int unsigned arrive_pct);
        int tol;
        int d;
        tol = regs.arrive_tolerance;
        if ($urandom_range(0, 99) < arrive_pct)
            d = int'($urandom_range(0, 2 * tol)) - tol;
        else if ($urandom_range(0, 4) < 3)
            d = ($urandom_range(0, 1) ? 1 : -1) * (tol + int'($urandom_range(1, 3)));
        else
            return $urandom;
        return m_target - 32'(d);
    endfunction

    task automatic send_request(input logic op, input logic [31:0] meas, input logic [63:0] fb);
        @(negedge clk);
        req_bus.valid <= 1'b1;
        req_bus.opcode <= op;
        req_bus.measured_position <= meas;
        req_bus.frame_bytes <= fb;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        expected_results.push_back(supervise_request(op, meas, fb));
        items_sent++;
    endtask

    task automatic send_tick(input logic [31:0] meas);
        send_request(OP_TICK, meas, {$urandom, $urandom});
    endtask

    task automatic send_frame(input logic [63:0] fb);
        send_request(OP_FRAME, $urandom, fb);
    endtask

    // Bursts of requests separated by short random gaps
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [dps_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dps_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            dps_pkg::CFG_FAULT_TIMEOUT:    regs.fault_timeout = value[15:0];
            dps_pkg::CFG_SETTLE_TICKS:     regs.settle_ticks = value[15:0];
            dps_pkg::CFG_ARRIVE_TOLERANCE: regs.arrive_tolerance = value[7:0];
            dps_pkg::CFG_TEST_OFFSET:      regs.test_offset = value;
            dps_pkg::CFG_REFERENCE_SCALE:  regs.reference_scale = value[7:0];
            default:                       ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        failures++;
    endtask

    task automatic test_wait_mode();
        send_tick(32'h0000_0000);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h8000_0000);
        send_tick(32'hFFFF_FFFF);
    endtask

    task automatic test_frame_decode();
        // broken checksum changes nothing
        send_frame(make_frame(16'd100, 8'h00) ^ (64'd1 << 56));
        send_frame(make_frame(16'h7FFF, 8'h00));
        send_frame(make_frame(16'h8000, 8'h00));
        send_frame(make_frame(16'd2047, dps_pkg::CTRL_STAGE_ON | dps_pkg::CTRL_BRAKE_OFF));
        send_frame(make_frame(-16'sd2048, 8'h00));
        send_frame(make_frame(16'd2048, 8'hFF & ~dps_pkg::CTRL_POWER_ON));
        send_frame(make_frame(-16'sd2049, 8'h00));
        send_frame(make_frame(16'd0, 8'h00));
        send_tick(32'h8000_0000);
    endtask

    task automatic test_config_port();
        wait_drained();
        write_register(dps_pkg::CFG_REFERENCE_SCALE, 20'd255);
        send_frame(make_frame(16'd2047, 8'h00));
        send_tick($urandom);
        wait_drained();
        // scale zero puts every accepted target on the zero phase
        write_register(dps_pkg::CFG_REFERENCE_SCALE, 20'd0);
        send_frame(make_frame(-16'sd1000, 8'h00));
        send_tick($urandom);
        wait_drained();
        write_register(dps_pkg::CFG_REFERENCE_SCALE, 20'd1);
        write_register(CFG_UNUSED_IDX, 20'hFFFFF);
        send_frame(make_frame(16'd5, 8'h00));
        send_tick($urandom);
        wait_drained();
        write_register(dps_pkg::CFG_FAULT_TIMEOUT, 20'd1);
        write_register(dps_pkg::CFG_FAULT_TIMEOUT, 20'd65535);
        write_register(dps_pkg::CFG_SETTLE_TICKS, 20'd65535);
        write_register(dps_pkg::CFG_SETTLE_TICKS, 20'd0);
        write_register(dps_pkg::CFG_ARRIVE_TOLERANCE, 20'd255);
        write_register(dps_pkg::CFG_ARRIVE_TOLERANCE, 20'd0);
        write_register(dps_pkg::CFG_TEST_OFFSET, 20'hFFFFF);
        write_register(dps_pkg::CFG_TEST_OFFSET, 20'd0);
        send_tick($urandom);
    endtask

    task automatic retune_tolerance();
        case ($urandom_range(0, 3))
            0:       write_register(dps_pkg::CFG_ARRIVE_TOLERANCE, 20'd0);
            1:       write_register(dps_pkg::CFG_ARRIVE_TOLERANCE, 20'd255);
            default: write_register(dps_pkg::CFG_ARRIVE_TOLERANCE,
                                    20'($urandom_range(1, 20)));
        endcase
        write_register(dps_pkg::CFG_SETTLE_TICKS, 20'($urandom_range(0, 60)));
    endtask

    task automatic test_self_test_moves(input int unsigned budget);
        int unsigned n;
        int unsigned in_mode;
        int unsigned linger;
        logic [2:0]  last_mode;
        wait_drained();
        if (ending == END_TEST_TIMEOUT)
            case ($urandom_range(0, 2))
                0:       write_register(dps_pkg::CFG_FAULT_TIMEOUT, 20'd0);
                1:       write_register(dps_pkg::CFG_FAULT_TIMEOUT, 20'd1);
                default: write_register(dps_pkg::CFG_FAULT_TIMEOUT,
                                        20'($urandom_range(2, 40)));
            endcase
        else
            write_register(dps_pkg::CFG_FAULT_TIMEOUT, 20'd65535);
        case ($urandom_range(0, 2))
            0:       write_register(dps_pkg::CFG_TEST_OFFSET, 20'd0);
            1:       write_register(dps_pkg::CFG_TEST_OFFSET, 20'hFFFFF);
            default: write_register(dps_pkg::CFG_TEST_OFFSET, 20'($urandom));
        endcase
        write_register(dps_pkg::CFG_REFERENCE_SCALE, 20'($urandom_range(1, 255)));
        retune_tolerance();
        n = 0;
        in_mode = 0;
        linger = $urandom_range(20, 120);
        last_mode = m_mode;
        while (m_mode != MODE_LAUNCH && m_mode != MODE_FAULT)
        begin
            pace();
            if (m_mode == MODE_WAIT && $urandom_range(0, 1) == 0)
                send_frame(make_frame(16'($urandom), 8'($urandom) | dps_pkg::CTRL_POWER_ON));
            else if (n < budget && $urandom_range(0, 99) < 12)
                send_frame(random_frame());
            else
                send_tick(tick_position((in_mode >= linger || n >= budget) ? 60 : 0));
            n++;
            if (m_mode != last_mode)
            begin
                last_mode = m_mode;
                in_mode = 0;
                linger = $urandom_range(20, 120);
            end
            else
                in_mode++;
            if (n % 150 == 149)
            begin
                wait_drained();
                retune_tolerance();
            end
        end
    endtask

    task automatic test_launch(input int unsigned dummy_ticks);
        if (m_mode != MODE_LAUNCH)
            return;
        if (ending == END_LAUNCH_REFUSED)
            send_frame(make_frame(16'($urandom), 8'($urandom) & ~dps_pkg::CTRL_STAGE_ON));
        else
        begin
            // power on first and hold the brake, then release it
            send_frame(make_frame(16'($urandom), dps_pkg::CTRL_STAGE_ON));
            repeat (dummy_ticks) send_tick(tick_position(50));
            send_frame(make_frame(16'($urandom),
                                  dps_pkg::CTRL_STAGE_ON | dps_pkg::CTRL_BRAKE_OFF));
        end
        repeat (dummy_ticks) send_tick(tick_position(50));
    endtask

    task automatic test_steady_random(input int unsigned upto);
        while (items_sent < upto)
        begin
            pace();
            if ($urandom_range(0, 99) < 30)
                send_frame(random_frame());
            else
                send_tick(tick_position(30));
        end
    endtask

    task automatic test_backpressure();
        hold_off_requests++;
        repeat (40)
        begin
            if ($urandom_range(0, 1) == 0)
                send_frame(random_frame());
            else
                send_tick($urandom);
        end
        // pause until the block has drained
        wait_drained();
    endtask

    // Result side: stall patterns, plus long hold-offs on request
    initial
    begin
        int unsigned pattern;
        int unsigned pattern_left;
        int unsigned phase;
        pattern = 0;
        pattern_left = 0;
        phase = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_served != hold_off_requests)
            begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_served++;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                phase++;
                case (pattern)
                    0:       res_bus.ready <= 1'b1;
                    1:       res_bus.ready <= 1'($urandom_range(0, 1));
                    2:       res_bus.ready <= (phase % 3) != 0;
                    default: res_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        dps_pkg::res_t got;
        dps_pkg::res_t want;
        if (rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            got.mode_index = res_bus.mode_index;
            got.status_byte = res_bus.status_byte;
            got.motor_enable = res_bus.motor_enable;
            got.brake_release = res_bus.brake_release;
            got.regulate = res_bus.regulate;
            got.position_error = res_bus.position_error;
            got.frame_ok = res_bus.frame_ok;
            got.command_reference = res_bus.command_reference;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %0h", $time, got);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.mode_index !== want.mode_index)
                    report_field("mode_index", want.mode_index, got.mode_index);
                if (got.status_byte !== want.status_byte)
                    report_field("status_byte", want.status_byte, got.status_byte);
                if (got.motor_enable !== want.motor_enable)
                    report_field("motor_enable", want.motor_enable, got.motor_enable);
                if (got.brake_release !== want.brake_release)
                    report_field("brake_release", want.brake_release, got.brake_release);
                if (got.regulate !== want.regulate)
                    report_field("regulate", want.regulate, got.regulate);
                if (got.position_error !== want.position_error)
                    report_field("position_error", want.position_error, got.position_error);
                if (got.frame_ok !== want.frame_ok)
                    report_field("frame_ok", want.frame_ok, got.frame_ok);
                if (got.command_reference !== want.command_reference)
                    report_field("command_reference", 32'(want.command_reference),
                                 32'(got.command_reference));
            end
        end
    end

    initial
    begin
        req_bus.valid = 1'b0;
        req_bus.opcode = OP_TICK;
        req_bus.measured_position = '0;
        req_bus.frame_bytes = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ending = ending_e'($urandom_range(0, 2));
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_wait_mode();
        test_frame_decode();
        test_config_port();
        test_self_test_moves(700);
        test_launch($urandom_range(1, 3));
        test_steady_random(900);
        test_backpressure();
        test_steady_random(TOTAL_REQUESTS);

        wait_drained();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
